>>> hw/rtl/video_memory_access_ports_top_macros.svh
// Assertion macros for the video memory access ports
`ifndef VIDEO_MEMORY_ACCESS_PORTS_TOP_MACROS_SVH
`define VIDEO_MEMORY_ACCESS_PORTS_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VMAP_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VMAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define VMAP_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define VMAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/vmap_pkg.sv
package vmap_pkg;
    localparam int VRAM_WORDS    = 32768;
    localparam int PALETTE_WORDS = 256;
    localparam int SPRITE_BYTES  = 544;
    localparam int VRAM_AW = $clog2(VRAM_WORDS);
    localparam int PAL_AW  = $clog2(PALETTE_WORDS);
    localparam int SPR_AW  = 10;
    localparam int VCLR_W  = (VRAM_AW > SPR_AW ? VRAM_AW : SPR_AW) + 1;

    localparam logic [5:0] R_INIDISP = 6'h00;
    localparam logic [5:0] R_OAMADDL = 6'h02;
    localparam logic [5:0] R_OAMADDH = 6'h03;
    localparam logic [5:0] R_OAMDATA = 6'h04;
    localparam logic [5:0] R_VMAIN   = 6'h15;
    localparam logic [5:0] R_VMADDL  = 6'h16;
    localparam logic [5:0] R_VMADDH  = 6'h17;
    localparam logic [5:0] R_VMDATAL = 6'h18;
    localparam logic [5:0] R_VMDATAH = 6'h19;
    localparam logic [5:0] R_CGADD   = 6'h21;
    localparam logic [5:0] R_CGDATA  = 6'h22;
    localparam logic [5:0] R_OAMREAD = 6'h38;
    localparam logic [5:0] R_VMRDL   = 6'h39;
    localparam logic [5:0] R_VMRDH   = 6'h3A;
    localparam logic [5:0] R_CGREAD  = 6'h3B;
    localparam logic [5:0] R_STAT    = 6'h3E;

    typedef struct packed {
        logic                 vram_we;
        logic [1:0]           vram_be;
        logic [VRAM_AW-1:0]   vram_waddr;
        logic [15:0]          vram_wdata;
        logic                 pal_we;
        logic [1:0]           pal_be;
        logic [PAL_AW-1:0]    pal_waddr;
        logic [7:0]           pal_wdata;
        logic                 spr_we;
        logic [1:0]           spr_be;
        logic [8:0]           spr_wrow;
        logic [15:0]          spr_wdata;
    } mem_wr_t;
endpackage

>>> hw/rtl/vmap_mem.sv
module vmap_mem
    import vmap_pkg::*;
(
    input  logic               aclk,
    input  mem_wr_t            wr,
    input  logic [VRAM_AW-1:0] vram_raddr,
    input  logic [PAL_AW-1:0]  pal_raddr,
    input  logic [8:0]         spr_rrow,
    output logic [15:0]        vram_rdata,
    output logic [15:0]        pal_rdata,
    output logic [15:0]        spr_rdata
);
    logic [7:0] vram_lo [VRAM_WORDS];
    logic [7:0] vram_hi [VRAM_WORDS];
    logic [7:0] pal_lo [PALETTE_WORDS];
    logic [7:0] pal_hi [PALETTE_WORDS];
    logic [7:0] spr_lo [SPRITE_BYTES/2];
    logic [7:0] spr_hi [SPRITE_BYTES/2];

    always_ff @(posedge aclk) begin
        if (wr.vram_we && wr.vram_be[0]) vram_lo[wr.vram_waddr] <= wr.vram_wdata[7:0];
        if (wr.vram_we && wr.vram_be[1]) vram_hi[wr.vram_waddr] <= wr.vram_wdata[15:8];
        vram_rdata <= {vram_hi[vram_raddr], vram_lo[vram_raddr]};
    end

    always_ff @(posedge aclk) begin
        if (wr.pal_we && wr.pal_be[0]) pal_lo[wr.pal_waddr] <= wr.pal_wdata;
        if (wr.pal_we && wr.pal_be[1]) pal_hi[wr.pal_waddr] <= wr.pal_wdata;
        pal_rdata <= {pal_hi[pal_raddr], pal_lo[pal_raddr]};
    end

    always_ff @(posedge aclk) begin
        if (wr.spr_we && wr.spr_be[0]) spr_lo[wr.spr_wrow] <= wr.spr_wdata[7:0];
        if (wr.spr_we && wr.spr_be[1]) spr_hi[wr.spr_wrow] <= wr.spr_wdata[15:8];
        spr_rdata <= {spr_hi[spr_rrow], spr_lo[spr_rrow]};
    end
endmodule

>>> hw/rtl/vmap_ctrl.sv
module vmap_ctrl
    import vmap_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output mem_wr_t            wr,
    output logic [VRAM_AW-1:0] vram_raddr,
    output logic [PAL_AW-1:0]  pal_raddr,
    output logic [8:0]         spr_rrow,
    input  logic [15:0]        vram_rdata,
    input  logic [15:0]        pal_rdata,
    input  logic [15:0]        spr_rdata,
    output logic               busy
);
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [VCLR_W-1:0] clr_reg, clr_next;
    logic              wreq_reg, wreq_next;
    logic [5:0]  addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic        vbl_reg, vbl_next;
    logic [14:0] vaddr_reg, vaddr_next;
    logic [15:0] pref_reg, pref_next;
    logic        pref_ld_reg, pref_ld_next;
    logic [7:0]  vmode_reg, vmode_next;
    logic        fblank_reg, fblank_next;
    logic [7:0]  paddr_reg, paddr_next;
    logic        phase_reg, phase_next;
    logic [8:0]  oword_reg, oword_next;
    logic [9:0]  obyte_reg, obyte_next;
    logic [7:0]  olatch_reg, olatch_next;
    logic        oend_reg, oend_next;
    logic [7:0]  bus_reg, bus_next;
    logic        mval_reg, mval_next;

    logic [14:0] vstep;
    logic [9:0]  sidx;
    logic [9:0]  obyte_p1;
    logic [7:0]  sbyte;

    assign s_tready = (state_reg == ST_IDLE) && !mval_reg;
    assign m_tvalid = mval_reg;
    assign m_tdata  = bus_reg;
    assign busy     = (state_reg == ST_CLEAR);

    assign vram_raddr = vaddr_reg[VRAM_AW-1:0];
    assign pal_raddr  = paddr_reg[PAL_AW-1:0];
    always_comb begin
        sidx = obyte_reg[9] ? {5'b10000, obyte_reg[4:0]} : {1'b0, obyte_reg[8:0]};
        spr_rrow = sidx[9:1];
        sbyte = sidx[0] ? spr_rdata[15:8] : spr_rdata[7:0];
    end

    always_comb begin
        unique case (vmode_reg[1:0])
            2'd0:    vstep = 15'd1;
            2'd1:    vstep = 15'd32;
            default: vstep = 15'd128;
        endcase
    end
    assign obyte_p1 = obyte_reg + 10'd1;

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        wreq_next = wreq_reg; addr_next = addr_reg; data_next = data_reg; vbl_next = vbl_reg;
        vaddr_next = vaddr_reg; pref_next = pref_reg; pref_ld_next = 1'b0;
        vmode_next = vmode_reg; fblank_next = fblank_reg;
        paddr_next = paddr_reg; phase_next = phase_reg;
        oword_next = oword_reg; obyte_next = obyte_reg;
        olatch_next = olatch_reg; oend_next = oend_reg;
        bus_next = bus_reg;
        mval_next = mval_reg && !m_tready;
        wr = '0;
        if (pref_ld_reg) pref_next = vram_rdata;
        unique case (state_reg)
            ST_CLEAR: begin
                wr.vram_we = 1'b1; wr.vram_be = 2'b11;
                wr.vram_waddr = clr_reg[VRAM_AW-1:0];
                wr.pal_we = 1'b1; wr.pal_be = 2'b11;
                wr.pal_waddr = clr_reg[PAL_AW-1:0];
                wr.spr_we = 1'b1; wr.spr_be = 2'b11;
                wr.spr_wrow = clr_reg[8:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == VCLR_W'(VRAM_WORDS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    wreq_next = s_tdata[0];
                    addr_next = s_tdata[6:1];
                    data_next = s_tdata[14:7];
                    vbl_next = s_tdata[15];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
                if (wreq_reg) begin
                    unique case (addr_reg) inside
                        R_INIDISP: fblank_next = data_reg[7];
                        R_OAMADDL: begin
                            oword_next = {oword_reg[8], data_reg};
                            obyte_next = {oword_reg[8], data_reg, 1'b0};
                        end
                        R_OAMADDH: begin
                            oword_next = {data_reg[0], oword_reg[7:0]};
                            obyte_next = {data_reg[0], oword_reg[7:0], 1'b0};
                        end
                        R_OAMDATA: begin
                            if (obyte_reg < 10'd544) begin
                                if (!obyte_reg[0]) olatch_next = data_reg;
                                wr.spr_wrow = obyte_reg[9:1];
                                wr.spr_wdata = {data_reg, data_reg};
                                if (!obyte_reg[9] && obyte_reg[0]) begin
                                    wr.spr_we = 1'b1; wr.spr_be = 2'b11;
                                    wr.spr_wdata = {data_reg, olatch_reg};
                                end else if (obyte_reg[9]) begin
                                    wr.spr_we = 1'b1;
                                    wr.spr_be = obyte_reg[0] ? 2'b10 : 2'b01;
                                end
                                obyte_next = obyte_p1;
                                oend_next = (obyte_p1 == 10'd544);
                            end
                        end
                        R_VMAIN: vmode_next = data_reg;
                        R_VMADDL: begin
                            vaddr_next = {vaddr_reg[14:8], data_reg};
                            state_next = ST_OUT;
                        end
                        R_VMADDH: begin
                            vaddr_next = {data_reg[6:0], vaddr_reg[7:0]};
                            state_next = ST_OUT;
                        end
                        R_VMDATAL, R_VMDATAH: begin
                            if (fblank_reg || vbl_reg) begin
                                wr.vram_we = 1'b1;
                                wr.vram_waddr = vaddr_reg[VRAM_AW-1:0];
                                wr.vram_wdata = {data_reg, data_reg};
                                wr.vram_be = (addr_reg == R_VMDATAL) ? 2'b01 : 2'b10;
                                if ((addr_reg == R_VMDATAL) != vmode_reg[7])
                                    vaddr_next = vaddr_reg + vstep;
                            end
                        end
                        R_CGADD: begin
                            paddr_next = data_reg;
                            phase_next = 1'b0;
                        end
                        R_CGDATA: begin
                            wr.pal_we = 1'b1;
                            wr.pal_waddr = paddr_reg[PAL_AW-1:0];
                            wr.pal_wdata = data_reg;
                            wr.pal_be = phase_reg ? 2'b10 : 2'b01;
                            phase_next = !phase_reg;
                            if (phase_reg) paddr_next = paddr_reg + 8'd1;
                        end
                        default: ;
                    endcase
                end else begin
                    mval_next = 1'b1;
                    unique case (addr_reg)
                        R_OAMREAD: begin
                            bus_next = sbyte;
                            obyte_next = obyte_p1;
                        end
                        R_VMRDL: begin
                            bus_next = pref_reg[7:0];
                            if (!vmode_reg[7]) begin
                                pref_next = vram_rdata;
                                vaddr_next = vaddr_reg + vstep;
                            end
                        end
                        R_VMRDH: begin
                            bus_next = pref_reg[15:8];
                            if (vmode_reg[7]) begin
                                pref_next = vram_rdata;
                                vaddr_next = vaddr_reg + vstep;
                            end
                        end
                        R_CGREAD: begin
                            phase_next = !phase_reg;
                            if (phase_reg) begin
                                bus_next = {1'b0, pal_rdata[14:8]};
                                paddr_next = paddr_reg + 8'd1;
                            end else begin
                                bus_next = pal_rdata[7:0];
                            end
                        end
                        R_STAT: bus_next = {1'b0, oend_reg, 6'b0};
                        default: ;
                    endcase
                end
            end
            ST_OUT: begin
                // memory read of new address is now valid next cycle
                pref_ld_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            pref_ld_reg <= 1'b0;
            vaddr_reg <= '0; pref_reg <= '0; vmode_reg <= '0; fblank_reg <= 1'b0;
            paddr_reg <= '0; phase_reg <= 1'b0;
            oword_reg <= '0; obyte_reg <= '0; olatch_reg <= '0; oend_reg <= 1'b0;
            bus_reg <= '0; mval_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            pref_ld_reg <= pref_ld_next;
            vaddr_reg <= vaddr_next; pref_reg <= pref_next;
            vmode_reg <= vmode_next; fblank_reg <= fblank_next;
            paddr_reg <= paddr_next; phase_reg <= phase_next;
            oword_reg <= oword_next; obyte_reg <= obyte_next;
            olatch_reg <= olatch_next; oend_reg <= oend_next;
            bus_reg <= bus_next; mval_reg <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        wreq_reg <= wreq_next; addr_reg <= addr_next; data_reg <= data_next; vbl_reg <= vbl_next;
    end
endmodule

>>> hw/rtl/video_memory_access_ports_top.sv
// Video memory access ports: CPU register window onto VRAM, palette and
// sprite memory, with VRAM address auto-increment and read prefetch.
// Input channel s_*: one bus request per transfer; tdata carries
// req_type, reg_addr, write_data, in_vblank from bit 0 up.
// Output channel m_*: one byte per read request, none per write.
// Each request is accepted in ST_IDLE, then handled in an execute state that reads
// the synchronous memories and writes back. A VRAM address write adds a
// further state (ST_OUT) so the prefetch latch reloads from the registered VRAM port.
// A read result appears in the cycle after the execute state and stays on
// m_tdata until taken; no new request is accepted while it waits.
// After reset a clearing pass writes zero to all memories, one entry of
// each per cycle, through all VRAM_WORDS (32768) VRAM entries before s_tready rises.
// The register-window state comes up zero at reset.
`include "video_memory_access_ports_top_macros.svh"
module video_memory_access_ports_top
    import vmap_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // req_type, reg_addr[5:0], write_data[7:0], in_vblank
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // read_data
);
    mem_wr_t            wr;
    logic [VRAM_AW-1:0] vram_raddr;
    logic [PAL_AW-1:0]  pal_raddr;
    logic [8:0]         spr_rrow;
    logic [15:0]        vram_rdata, pal_rdata, spr_rdata;
    logic               busy;

    vmap_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .wr,
        .vram_raddr, .pal_raddr, .spr_rrow,
        .vram_rdata, .pal_rdata, .spr_rdata, .busy
    );

    vmap_mem u_mem (
        .aclk, .wr, .vram_raddr, .pal_raddr, .spr_rrow,
        .vram_rdata, .pal_rdata, .spr_rdata
    );

    `VMAP_ASSERT_IMPL(a_no_accept_clear, aclk, aresetn, busy |-> !s_tready, "accept during clear")
    `VMAP_ASSERT_IMPL(a_no_accept_out, aclk, aresetn, m_tvalid |-> !s_tready, "accept with result")
    `VMAP_ASSERT_NEXT(a_accept_gap, aclk, aresetn, s_tvalid && s_tready, !s_tready, "back to back")
endmodule

>>> verif/testbench.sv
module testbench;
    import vmap_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    video_memory_access_ports_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [15:0] vram_mem [VRAM_WORDS];
    logic [15:0] pal_mem [PALETTE_WORDS];
    logic [7:0]  spr_mem [SPRITE_BYTES];
    logic [14:0] vaddr;
    logic [15:0] vprefetch;
    logic [7:0]  vmode;
    logic        fblank;
    logic [7:0]  paddr;
    logic        pphase;
    logic [8:0]  spr_word;
    logic [9:0]  spr_byte;
    logic [7:0]  spr_latch;
    logic        spr_end;
    logic [7:0]  bus_latch;

    logic [7:0] read_bytes_due [$];
    int errors = 0;
    int mismatches = 0;
    bit stall_out = 1'b0;

    task automatic vram_advance();
        case (vmode[1:0])
            2'd0: vaddr = vaddr + 15'd1;
            2'd1: vaddr = vaddr + 15'd32;
            default: vaddr = vaddr + 15'd128;
        endcase
    endtask

    task automatic predict_request(input logic wr, input logic [5:0] ra, input logic [7:0] d,
                                   input logic vb);
        int idx;
        logic [15:0] w;
        if (wr) begin
            case (ra)
                R_INIDISP: fblank = d[7];
                R_OAMADDL: begin
                    spr_word[7:0] = d;
                    spr_byte = {spr_word, 1'b0};
                end
                R_OAMADDH: begin
                    spr_word[8] = d[0];
                    spr_byte = {spr_word, 1'b0};
                end
                R_OAMDATA: begin
                    if (spr_byte < 10'd544) begin
                        if (!spr_byte[0]) spr_latch = d;
                        if (spr_byte < 10'h200 && spr_byte[0]) begin
                            spr_mem[spr_byte - 1] = spr_latch;
                            spr_mem[spr_byte] = d;
                        end
                        if (spr_byte >= 10'h200) spr_mem[spr_byte] = d;
                        spr_byte = spr_byte + 10'd1;
                        spr_end = (spr_byte == 10'd544);
                    end
                end
                R_VMAIN: vmode = d;
                R_VMADDL: begin
                    vaddr[7:0] = d;
                    vprefetch = vram_mem[vaddr % VRAM_WORDS];
                end
                R_VMADDH: begin
                    vaddr[14:8] = d[6:0];
                    vprefetch = vram_mem[vaddr % VRAM_WORDS];
                end
                R_VMDATAL: if (fblank || vb) begin
                    vram_mem[vaddr % VRAM_WORDS][7:0] = d;
                    if (!vmode[7]) vram_advance();
                end
                R_VMDATAH: if (fblank || vb) begin
                    vram_mem[vaddr % VRAM_WORDS][15:8] = d;
                    if (vmode[7]) vram_advance();
                end
                R_CGADD: begin
                    paddr = d;
                    pphase = 1'b0;
                end
                R_CGDATA: begin
                    idx = paddr % PALETTE_WORDS;
                    if (!pphase) begin
                        pal_mem[idx][7:0] = d;
                        pphase = 1'b1;
                    end else begin
                        pal_mem[idx][15:8] = d;
                        pphase = 1'b0;
                        paddr = paddr + 8'd1;
                    end
                end
                default: ;
            endcase
        end else begin
            case (ra)
                R_OAMREAD: begin
                    idx = spr_byte[9] ? (512 + spr_byte[4:0]) : spr_byte[8:0];
                    bus_latch = spr_mem[idx];
                    spr_byte = spr_byte + 10'd1;
                end
                R_VMRDL: begin
                    bus_latch = vprefetch[7:0];
                    if (!vmode[7]) begin
                        vprefetch = vram_mem[vaddr % VRAM_WORDS];
                        vram_advance();
                    end
                end
                R_VMRDH: begin
                    bus_latch = vprefetch[15:8];
                    if (vmode[7]) begin
                        vprefetch = vram_mem[vaddr % VRAM_WORDS];
                        vram_advance();
                    end
                end
                R_CGREAD: begin
                    w = pal_mem[paddr % PALETTE_WORDS];
                    if (!pphase) begin
                        pphase = 1'b1;
                        bus_latch = w[7:0];
                    end else begin
                        pphase = 1'b0;
                        paddr = paddr + 8'd1;
                        bus_latch = {1'b0, w[14:8]};
                    end
                end
                R_STAT: bus_latch = {1'b0, spr_end, 6'b0};
                default: ;
            endcase
            read_bytes_due.push_back(bus_latch);
        end
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (n != 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    bit gaps_on = 1'b1;

    task automatic send_request(input logic wr, input logic [5:0] ra, input logic [7:0] d,
                                input logic vb);
        if (gaps_on) idle_gap();
        s_tvalid <= 1'b1;
        s_tdata <= {vb, d, ra, wr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(wr, ra, d, vb);
    endtask

    task automatic rd(input logic [5:0] ra);
        send_request(1'b0, ra, 8'($urandom), 1'($urandom));
    endtask

    task automatic wr(input logic [5:0] ra, input logic [7:0] d, input logic vb);
        send_request(1'b1, ra, d, vb);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (read_bytes_due.size() == 0) begin
                    errors++;
                    if (mismatches < 10) $display("unexpected read_data %h", m_tdata);
                    mismatches++;
                end else begin
                    if (m_tdata !== read_bytes_due[0]) begin
                        errors++;
                        if (mismatches < 10)
                            $display("read_data mismatch: expected %h got %h",
                                     read_bytes_due[0], m_tdata);
                        mismatches++;
                    end
                    void'(read_bytes_due.pop_front());
                end
            end
            if (!stall_out)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= ($urandom_range(0, 19) == 0);
        end
    end

    always begin
        repeat ($urandom_range(50, 400)) @(posedge aclk);
        stall_out = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(5, 40)) @(posedge aclk);
        stall_out = 1'b0;
    end

    task automatic test_directed();
        int i;
        rd(R_VMRDL);
        rd(R_STAT);
        rd(6'h3F);
        wr(R_VMAIN, 8'h00, 1'b0);
        wr(R_VMADDL, 8'hFF, 1'b0);
        wr(R_VMADDH, 8'hFF, 1'b0);
        wr(R_VMDATAL, 8'hA5, 1'b0);
        wr(R_VMDATAL, 8'h5A, 1'b1);
        wr(R_VMDATAH, 8'hFF, 1'b1);
        wr(R_VMADDH, 8'h7F, 1'b0);
        rd(R_VMRDL);
        rd(R_VMRDH);
        wr(R_CGADD, 8'hFF, 1'b0);
        wr(R_CGDATA, 8'hFF, 1'b0);
        wr(R_CGDATA, 8'hFF, 1'b0);
        wr(R_CGADD, 8'hFF, 1'b0);
        rd(R_CGREAD);
        rd(R_CGREAD);
        wr(R_OAMADDL, 8'hFF, 1'b0);
        wr(R_OAMADDH, 8'h01, 1'b0);
        for (i = 0; i < 34; i++) wr(R_OAMDATA, 8'($urandom), 1'b0);
        rd(R_STAT);
        wr(R_OAMDATA, 8'h11, 1'b0);
        rd(R_OAMREAD);
        rd(6'h10);
    endtask

    task automatic test_vram();
        int i, n;
        wr(R_INIDISP, {1'($urandom), 7'($urandom)}, 1'b0);
        wr(R_VMAIN, {1'($urandom), 5'($urandom), 2'($urandom)}, 1'b0);
        wr(R_VMADDL, 8'($urandom), 1'b0);
        wr(R_VMADDH, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)), 1'b0);
        n = $urandom_range(2, 12);
        for (i = 0; i < n; i++)
            wr($urandom_range(0, 1) ? R_VMDATAH : R_VMDATAL, 8'($urandom), 1'($urandom));
        wr(R_VMADDL, 8'($urandom), 1'b0);
        for (i = 0; i < n; i++) rd($urandom_range(0, 1) ? R_VMRDH : R_VMRDL);
    endtask

    task automatic test_palette();
        int i, n;
        wr(R_CGADD, 8'($urandom), 1'($urandom));
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) wr(R_CGDATA, 8'($urandom), 1'($urandom));
        wr(R_CGADD, 8'($urandom_range(0, 3)) + 8'($urandom_range(0, 1) ? 0 : 8'hFC), 1'b0);
        for (i = 0; i < n; i++) rd(R_CGREAD);
    endtask

    task automatic test_sprite();
        int i, n;
        wr(R_OAMADDL, 8'($urandom), 1'b0);
        wr(R_OAMADDH, 8'($urandom), 1'b0);
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) wr(R_OAMDATA, 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 1)) rd(R_STAT);
        for (i = 0; i < n; i++) rd(R_OAMREAD);
        rd(R_STAT);
    endtask

    task automatic test_noise();
        int i;
        for (i = 0; i < 6; i++) send_request(1'($urandom), 6'($urandom), 8'($urandom),
                                             1'($urandom));
    endtask

    task automatic drain();
        int n;
        s_tvalid <= 1'b0;
        n = 0;
        while (read_bytes_due.size() != 0 && n < 20000) begin
            @(posedge aclk);
            n++;
        end
        repeat (10) @(posedge aclk);
    endtask

    initial begin
        int k;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (vram_mem[i]) vram_mem[i] = '0;
        foreach (pal_mem[i]) pal_mem[i] = '0;
        foreach (spr_mem[i]) spr_mem[i] = '0;
        vaddr = '0; vprefetch = '0; vmode = '0; fblank = 1'b0;
        paddr = '0; pphase = 1'b0; spr_word = '0; spr_byte = '0;
        spr_latch = '0; spr_end = 1'b0; bus_latch = '0;
        test_directed();
        for (k = 0; k < 87; k++) begin
            gaps_on = (k % 8 != 3);
            case ($urandom_range(0, 3))
                0: test_vram();
                1: test_palette();
                2: test_sprite();
                default: test_noise();
            endcase
        end
        drain();
        if (errors == 0 && read_bytes_due.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #12000000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule

>>> video_memory_access_ports_top.f
+incdir+hw/rtl
hw/rtl/vmap_pkg.sv
hw/rtl/vmap_mem.sv
hw/rtl/vmap_ctrl.sv
hw/rtl/video_memory_access_ports_top.sv
verif/testbench.sv
